### rtl/core/bpra_pkg.sv
// shared types, constants and helpers for the bitmap page run allocator
`timescale 1ns / 1ps

package bpra_pkg;

    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = 6;
    localparam int PAGE_W    = 12;
    localparam int STATUS_W  = 2;
    localparam int RESV_W    = 13;
    localparam int COUNT_MAX = 63;

    localparam logic [RESV_W-1:0] RESV_RESET = 13'd3072;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_NOT_USED = 2'd2
    } status_t;

    // per-word verdict coming out of the scan unit
    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } scan_res_t;

    // ones in the low n bits, n from 0 to 32
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [COUNT_W-1:0] n);
        logic [WORD_BITS:0] wide;
        wide = ((WORD_BITS+1)'(1) << n) - (WORD_BITS+1)'(1);
        return wide[WORD_BITS-1:0];
    endfunction

endpackage

### rtl/core/bpra_req_if.sv
// request channel: operation, page count and start page
`timescale 1ns / 1ps

interface bpra_req_if;
    import bpra_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [COUNT_W-1:0]  page_count;
    logic [PAGE_W-1:0]   start_page;

    modport source (output valid, operation, page_count, start_page, input ready);
    modport sink   (input valid, operation, page_count, start_page, output ready);
endinterface

### rtl/core/bpra_resp_if.sv
// response channel: status and granted page
`timescale 1ns / 1ps

interface bpra_resp_if;
    import bpra_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_number;

    modport source (output valid, status, page_number, input ready);
    modport sink   (input valid, status, page_number, output ready);
endinterface

### rtl/core/bpra_bitmap_ram.sv
// used-page bitmap storage, one write port and one registered read port
`timescale 1ns / 1ps

module bpra_bitmap_ram #(
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [bpra_pkg::WORD_BITS-1:0] wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [bpra_pkg::WORD_BITS-1:0] rdata
);
    import bpra_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/bpra_scan_unit.sv
// shared run matcher: one bitmap word per beat, carries the open free run
`timescale 1ns / 1ps

module bpra_scan_unit #(
    parameter int NUM_PAGES = 4096,
    localparam int WORDS = (NUM_PAGES + bpra_pkg::WORD_BITS - 1) / bpra_pkg::WORD_BITS,
    localparam int AW    = $clog2(WORDS),
    localparam int PGW   = AW + 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clr,
    input  logic                           in_valid,
    input  logic [bpra_pkg::WORD_BITS-1:0] word_data,
    input  logic [AW-1:0]                  word_idx,
    input  logic [bpra_pkg::RESV_W-1:0]    reserved,
    input  logic [bpra_pkg::COUNT_W-1:0]   count,
    output bpra_pkg::scan_res_t            res,
    output logic [PGW-1:0]                 page
);
    import bpra_pkg::*;

    localparam int CW   = ((PGW > RESV_W) ? PGW : RESV_W) + 1;
    localparam int TAIL = NUM_PAGES - (WORDS - 1) * WORD_BITS;
    localparam logic [AW-1:0]        LAST_WORD = AW'(WORDS - 1);
    localparam logic [WORD_BITS-1:0] LAST_MASK = low_mask(COUNT_W'(TAIL));
    localparam logic [COUNT_W-1:0]   WORD_CNT  = COUNT_W'(WORD_BITS);

    // stage one: free mask of the word
    logic [CW-1:0]        base_c;
    logic [CW-1:0]        resv_c;
    logic [CW-1:0]        diff_c;
    logic [WORD_BITS-1:0] resv_mask;
    logic [WORD_BITS-1:0] free_mask;

    logic                 v1_reg;
    logic [WORD_BITS-1:0] f_reg;
    logic [AW-1:0]        w1_reg;

    always_comb
    begin
        base_c = CW'({word_idx, 5'b0});
        resv_c = CW'(reserved);
        diff_c = resv_c - base_c;
        if (resv_c <= base_c)
        begin
            resv_mask = '0;
        end
        else if (diff_c >= CW'(WORD_BITS))
        begin
            resv_mask = '1;
        end
        else
        begin
            resv_mask = low_mask(diff_c[COUNT_W-1:0]);
        end
        free_mask = ~word_data & ~resv_mask & ((word_idx == LAST_WORD) ? LAST_MASK : '1);
    end

    // stage two: run search inside the word and across the word boundary
    logic [WORD_BITS-1:0] g1, g2, g4, g8, g16, g32, gsel, run_hits;
    logic [4:0]           sh;
    logic [4:0]           hit_bit;
    logic                 hit_b;
    logic                 hit_a;
    logic                 all_free;
    logic [COUNT_W-1:0]   lead;
    logic [COUNT_W-1:0]   need;
    logic [COUNT_W-1:0]   run_reg;
    logic [COUNT_W-1:0]   run_next;
    logic [PGW-1:0]       page_a;
    logic [PGW-1:0]       page_b;
    scan_res_t            res_reg;
    logic [PGW-1:0]       page_reg;

    always_comb
    begin
        // doubling: g_k bit s set when bits s..s+k-1 are all free
        g1  = f_reg;
        g2  = g1 & (g1 >> 1);
        g4  = g2 & (g2 >> 2);
        g8  = g4 & (g4 >> 4);
        g16 = g8 & (g8 >> 8);
        g32 = g16 & (g16 >> 16);
        gsel = '0;
        sh   = '0;
        if (count > WORD_CNT)
        begin
            gsel = '0;
        end
        else if (count[5])
        begin
            gsel = g32;
        end
        else if (count[4])
        begin
            gsel = g16;
            sh   = {1'b0, count[3:0]};
        end
        else if (count[3])
        begin
            gsel = g8;
            sh   = {2'b0, count[2:0]};
        end
        else if (count[2])
        begin
            gsel = g4;
            sh   = {3'b0, count[1:0]};
        end
        else if (count[1])
        begin
            gsel = g2;
            sh   = {4'b0, count[0]};
        end
        else if (count[0])
        begin
            gsel = g1;
        end
        run_hits = gsel & (gsel >> sh);

        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (run_hits[i])
            begin
                hit_bit = 5'(i);
            end
        end
        hit_b = |run_hits;

        lead = WORD_CNT;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (!f_reg[i])
            begin
                lead = COUNT_W'(WORD_BITS - 1 - i);
            end
        end
        all_free = &f_reg;

        // open run from earlier words finishing in the low bits of this one
        need  = (count > run_reg) ? (count - run_reg) : '0;
        hit_a = (run_reg != '0) && (need <= WORD_CNT) && (&(f_reg | ~low_mask(need)));

        page_a = {w1_reg, 5'b0} - PGW'(run_reg);
        page_b = {w1_reg, hit_bit};

        if (all_free)
        begin
            run_next = (run_reg >= WORD_CNT) ? '1 : (run_reg + WORD_CNT);
        end
        else
        begin
            run_next = lead;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            res_reg <= '0;
            run_reg <= '0;
        end
        else if (clr)
        begin
            v1_reg        <= 1'b0;
            res_reg.valid <= 1'b0;
            run_reg       <= '0;
        end
        else
        begin
            v1_reg        <= in_valid;
            res_reg.valid <= v1_reg;
            if (v1_reg)
            begin
                res_reg.hit  <= hit_a | hit_b;
                res_reg.last <= (w1_reg == LAST_WORD);
                run_reg      <= run_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg  <= free_mask;
        w1_reg <= word_idx;
        if (v1_reg)
        begin
            page_reg <= hit_a ? page_a : page_b;
        end
    end

    assign res  = res_reg;
    assign page = page_reg;

endmodule

### rtl/core/bitmap_page_run_allocator.sv
// top level: first-fit contiguous page allocator over a used-page bitmap
// alloc: one bitmap word scanned per cycle; a hit then marks the run in the bitmap (1 to 3 words)
//   by reading and then writing each word in turn; a failed scan or a bad count answers no space
// free: checks the range and that the start page is used, then clears the run word by word; one item at a time
// the scan rate is set by the single read port of the bitmap ram feeding the shared matcher
// after reset a clearing pass writes every word to zero, with req.ready low
`timescale 1ns / 1ps

module bitmap_page_run_allocator #(
    parameter int NUM_PAGES = 4096,
    parameter int MAX_RUN   = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bpra_pkg::RESV_W-1:0] cfg_wr_data,
    bpra_req_if.sink                    req,
    bpra_resp_if.source                 resp
);
    import bpra_pkg::*;

    localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = $clog2(WORDS);
    localparam int PGW   = AW + 5;
    localparam int CW    = ((PGW > RESV_W) ? PGW : RESV_W) + 1;
    localparam int SAT_RUN = (MAX_RUN < COUNT_MAX) ? MAX_RUN : COUNT_MAX;
    localparam logic [AW-1:0]      LAST_WORD   = AW'(WORDS - 1);
    localparam logic [CW-1:0]      NUM_PAGES_C = CW'(NUM_PAGES);
    localparam logic [COUNT_W-1:0] RUN_LIMIT   = COUNT_W'(SAT_RUN);
    localparam logic [COUNT_W-1:0] WORD_CNT    = COUNT_W'(WORD_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FCHK,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RESP
    } state_t;

    state_t               state_reg, state_next;
    logic [RESV_W-1:0]    reserved_reg;
    logic [AW-1:0]        word_reg, word_next;
    logic                 iss_on_reg, iss_on_next;
    logic                 rd_v_reg, rd_v_next;
    logic [AW-1:0]        rd_w_reg;
    logic                 op_reg, op_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [4:0]           bit_reg, bit_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [PGW-1:0]       first_reg, first_next;
    status_t              res_status_reg, res_status_next;
    logic [PAGE_W-1:0]    res_page_reg, res_page_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [PAGE_W-1:0]    out_page_reg, out_page_next;

    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic                 scan_clr;
    scan_res_t            scan_res;
    logic [PGW-1:0]       scan_page;

    logic [CW-1:0]        start_c;
    logic [CW-1:0]        resv_c;
    logic [CW-1:0]        first_c;
    logic [PGW-1:0]       start_pg;
    logic [COUNT_W-1:0]   free_cnt;
    logic [COUNT_W-1:0]   room;
    logic [COUNT_W-1:0]   chunk;
    logic [WORD_BITS-1:0] chunk_mask;

    bpra_bitmap_ram #(
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (word_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bpra_scan_unit #(
        .NUM_PAGES (NUM_PAGES)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (scan_clr),
        .in_valid  (rd_v_reg),
        .word_data (mem_rdata),
        .word_idx  (rd_w_reg),
        .reserved  (reserved_reg),
        .count     (count_reg),
        .res       (scan_res),
        .page      (scan_page)
    );

    assign start_c  = CW'(req.start_page);
    assign resv_c   = CW'(reserved_reg);
    assign first_c  = CW'(first_reg);
    assign start_pg = PGW'(req.start_page);
    assign free_cnt = (req.page_count > RUN_LIMIT) ? RUN_LIMIT : req.page_count;

    // bits of the current word covered by the run
    assign room       = WORD_CNT - COUNT_W'(bit_reg);
    assign chunk      = (rem_reg > room) ? room : rem_reg;
    assign chunk_mask = low_mask(chunk) << bit_reg;

    assign req.ready        = (state_reg == ST_IDLE);
    assign resp.valid       = out_valid_reg;
    assign resp.status      = out_status_reg;
    assign resp.page_number = out_page_reg;

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        iss_on_next     = iss_on_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        bit_next        = bit_reg;
        rem_next        = rem_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = word_reg;
        scan_clr        = 1'b0;

        if (out_valid_reg && resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    count_next      = req.page_count;
                    res_status_next = STATUS_DONE;
                    res_page_next   = '0;
                    if (req.operation == OP_ALLOC)
                    begin
                        if (req.page_count == '0 || req.page_count > RUN_LIMIT)
                        begin
                            res_status_next = STATUS_NO_SPACE;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            scan_clr    = 1'b1;
                            word_next   = '0;
                            iss_on_next = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (start_c >= NUM_PAGES_C || start_c < resv_c)
                        begin
                            res_status_next = STATUS_NOT_USED;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = start_pg[PGW-1:5];
                            word_next  = start_pg[PGW-1:5];
                            bit_next   = start_pg[4:0];
                            rem_next   = free_cnt;
                            state_next = ST_FCHK;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (iss_on_reg)
                begin
                    mem_re = 1'b1;
                    if (word_reg == LAST_WORD)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
                if (scan_res.valid)
                begin
                    if (scan_res.hit)
                    begin
                        iss_on_next   = 1'b0;
                        first_next    = scan_page;
                        word_next     = scan_page[PGW-1:5];
                        bit_next      = scan_page[4:0];
                        rem_next      = count_reg;
                        res_page_next = PAGE_W'(scan_page);
                        state_next    = ST_RMW_RD;
                    end
                    else if (scan_res.last)
                    begin
                        iss_on_next     = 1'b0;
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = ST_RESP;
                    end
                end
            end
            ST_FCHK:
            begin
                if (!mem_rdata[bit_reg])
                begin
                    res_status_next = STATUS_NOT_USED;
                    state_next      = ST_RESP;
                end
                else if (rem_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_RMW_RD;
                end
            end
            ST_RMW_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (op_reg == OP_FREE) ? (mem_rdata & ~chunk_mask)
                                                : (mem_rdata | chunk_mask);
                rem_next  = rem_reg - chunk;
                bit_next  = '0;
                // a free that runs past the last page stops at the last word
                if (rem_reg == chunk || word_reg == LAST_WORD)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = ST_RMW_RD;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = res_page_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_v_next = mem_re && (state_reg == ST_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            reserved_reg   <= RESV_RESET;
            word_reg       <= '0;
            iss_on_reg     <= 1'b0;
            rd_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_DONE;
            res_status_reg <= STATUS_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            iss_on_reg     <= iss_on_next;
            rd_v_reg       <= rd_v_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            res_status_reg <= res_status_next;
            if (cfg_wr_en)
            begin
                reserved_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_w_reg     <= word_reg;
        op_reg       <= op_next;
        count_reg    <= count_next;
        bit_reg      <= bit_next;
        rem_reg      <= rem_next;
        first_reg    <= first_next;
        res_page_reg <= res_page_next;
        out_page_reg <= out_page_next;
    end

    // a granted run never starts inside the reserved area
    a_grant_above_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW_RD && op_reg == OP_ALLOC) |-> (first_c >= resv_c))
        else $error("granted run starts below reserved boundary");

    // the read-modify-write loop only runs with pages left to touch
    a_rmw_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW_RD) |-> (rem_reg != '0))
        else $error("bitmap update entered with empty run");

    // the bitmap is only written by the clearing pass or an update beat
    a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_RMW_WR))
        else $error("bitmap written outside clear or update");

    // a new response only appears out of the response state
    a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("response raised without a finished request");

endmodule
